// ===== hdl/sli_pkg.sv =====
package sli_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_W     = 8;
    localparam int OUT_COUNT_W = 5;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_DELETED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic signed [VALUE_W-1:0]   value;
    } t_sli_in;

    typedef struct packed {
        logic [1:0]                  status;
        logic [OUT_COUNT_W-1:0]      entry_count;
        logic signed [VALUE_W-1:0]   smallest;
    } t_sli_out;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                        ins_we;
        logic                        del_go;
        logic signed [VALUE_W-1:0]   value;
    } t_sli_cmd;

endpackage

// ===== hdl/sli_cell.sv =====
module sli_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                              i_clk,
    input  sli_pkg::t_sli_cmd                 i_cmd,
    input  logic [CNT_W-1:0]                  i_count,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_left_value,
    input  logic                              i_left_lt,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_right_value,
    input  logic                              i_found,
    output logic signed [sli_pkg::VALUE_W-1:0] o_value,
    output logic                              o_lt,
    output logic                              o_found,
    output logic signed [sli_pkg::VALUE_W-1:0] o_next_value
);

    logic signed [sli_pkg::VALUE_W-1:0] r_value;
    logic signed [sli_pkg::VALUE_W-1:0] n_value;
    logic                               occupied;

    assign occupied = (CNT_W'(INDEX) < i_count);

    // sorted order makes this flag monotone along the chain
    assign o_lt    = occupied && (i_cmd.value > r_value);
    // first equal entry at or before this cell
    assign o_found = i_found || (occupied && (r_value == i_cmd.value));

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins_we && !o_lt) begin
            n_value = i_left_lt ? i_cmd.value : i_left_value;
        end else if (i_cmd.del_go && o_found) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

// ===== hdl/sorted_list_insert_delete.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      i_in  (mode, value)
// result    out        o_done one-cycle strobe   o_out (status, entry_count, smallest)
//
// One command is taken per cycle; busy stays low, so commands may arrive back to back.
// The result of a command appears on o_out with o_done in the cycle after it is taken;
// the whole chain of compare-and-shift cells settles combinationally in the cycle it is taken.
// Reset (synchronous, active low) empties the list and drops any pending result.
// The receiver cannot stall: o_done is high for one cycle, while o_out holds the result.
module sorted_list_insert_delete #(
    parameter int CAPACITY = sli_pkg::CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sli_pkg::t_sli_in  i_in,
    output logic              o_done,
    output sli_pkg::t_sli_out o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_done;
    sli_pkg::t_sli_out r_out;
    sli_pkg::t_sli_out n_out;

    sli_pkg::t_sli_cmd cmd;
    logic              take;
    logic              full;

    logic signed [sli_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic signed [sli_pkg::VALUE_W-1:0] cell_next  [CAPACITY];
    logic signed [sli_pkg::VALUE_W-1:0] head_next;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] found;

    // every command completes in the cycle it is taken
    assign busy = 1'b0;
    assign take = start && !busy;
    assign full = (r_count == CNT_W'(CAPACITY));

    assign cmd.ins_we = take && (i_in.mode == sli_pkg::MODE_INSERT) && !full;
    assign cmd.del_go = take && (i_in.mode == sli_pkg::MODE_DELETE);
    assign cmd.value  = i_in.value;

    // chain of cells: insert shifts right from the slot, delete shifts left onto the match
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [sli_pkg::VALUE_W-1:0] left_value;
        logic signed [sli_pkg::VALUE_W-1:0] right_value;
        logic                               left_lt;
        logic                               found_in;

        if (g == 0) begin : g_first
            assign left_value = cmd.value;
            assign left_lt    = 1'b1;
            assign found_in   = 1'b0;
        end else begin : g_mid
            assign left_value = cell_value[g-1];
            assign left_lt    = lt[g-1];
            assign found_in   = found[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // the last slot falls out of use on delete; hold its value
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        sli_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_count       (r_count),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .i_found       (found_in),
            .o_value       (cell_value[g]),
            .o_lt          (lt[g]),
            .o_found       (found[g]),
            .o_next_value  (cell_next[g])
        );
    end

    // the head after this command is the next value of the first cell
    assign head_next = cell_next[0];

    // count update and result formation
    always_comb begin
        n_count = r_count;
        n_out   = r_out;
        if (take) begin
            if (i_in.mode == sli_pkg::MODE_INSERT) begin
                if (full) begin
                    n_out.status = sli_pkg::ST_FULL;
                end else begin
                    n_count      = r_count + CNT_W'(1);
                    n_out.status = sli_pkg::ST_INSERTED;
                end
            end else begin
                if (found[CAPACITY-1]) begin
                    n_count      = r_count - CNT_W'(1);
                    n_out.status = sli_pkg::ST_DELETED;
                end else begin
                    n_out.status = sli_pkg::ST_NOT_FOUND;
                end
            end
            n_out.entry_count = sli_pkg::OUT_COUNT_W'(n_count);
            n_out.smallest    = (n_count != '0) ? head_next : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= take;
        end
    end

    // result payload: hold between commands
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule
